// File: rtl/s256_pkg.sv
package s256_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned WADDR_W     = $clog2(BLOCK_WORDS);
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // controls for the working variables and the chaining value
  typedef struct packed {
    logic       init;
    logic       step;
    logic       fold;
    logic       restart;
    logic [5:0] k_idx;
  } round_ctl_t;

  // controls for the message schedule stage
  typedef struct packed {
    logic capture;
    logic calc;
    logic early;
  } sched_ctl_t;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: rtl/s256_wmem.sv
module s256_wmem (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [3:0]                      be_i,
  input  logic [s256_pkg::WADDR_W-1:0]    waddr_i,
  input  logic [31:0]                     wdata_i,
  input  logic [s256_pkg::WADDR_W-1:0]    raddr0_i,
  input  logic [s256_pkg::WADDR_W-1:0]    raddr1_i,
  output logic [31:0]                     rdata0_o,
  output logic [31:0]                     rdata1_o
);

  // message block and rolling schedule share this store
  logic [31:0] mem [s256_pkg::BLOCK_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < 4; b++) begin
        if (be_i[b]) begin
          mem[waddr_i][8*b +: 8] <= wdata_i[8*b +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

// File: rtl/s256_sched.sv
module s256_sched (
  input  logic                 clk_i,
  input  s256_pkg::sched_ctl_t ctl_i,
  input  logic [31:0]          rdata0_i,
  input  logic [31:0]          rdata1_i,
  output logic [31:0]          w_o,
  output logic [31:0]          w_q_o
);

  logic [31:0] w2_q, w7_q, w_q;

  // first read pair brings w[t-2] and w[t-7], second pair w[t-15] and w[t-16]
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      w2_q <= rdata0_i;
      w7_q <= rdata1_i;
    end
    if (ctl_i.calc) begin
      w_q <= w_o;
    end
  end

  always_comb begin
    if (ctl_i.early) begin
      w_o = rdata1_i;
    end else begin
      w_o = s256_pkg::small_sigma1(w2_q) + w7_q + s256_pkg::small_sigma0(rdata0_i) + rdata1_i;
    end
  end

  assign w_q_o = w_q;

endmodule

// File: rtl/s256_round.sv
module s256_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  s256_pkg::round_ctl_t ctl_i,
  input  logic [31:0]          w_i,
  input  logic [2:0]           word_sel_i,
  output logic [31:0]          word_o
);

  logic [31:0] hash_q [8];
  logic [31:0] v_q [8];
  logic [31:0] t1, t2, ch, maj;

  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + s256_pkg::big_sigma1(v_q[4]) + ch + s256_pkg::ROUND_K[ctl_i.k_idx] + w_i;
    t2  = s256_pkg::big_sigma0(v_q[0]) + maj;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      for (int j = 0; j < 8; j++) begin
        v_q[j] <= hash_q[j];
      end
    end else if (ctl_i.step) begin
      for (int j = 1; j < 8; j++) begin
        v_q[j] <= v_q[j-1];
      end
      v_q[4] <= v_q[3] + t1;
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= s256_pkg::HASH_INIT;
    end else if (ctl_i.restart) begin
      hash_q <= s256_pkg::HASH_INIT;
    end else if (ctl_i.fold) begin
      for (int j = 0; j < 8; j++) begin
        hash_q[j] <= hash_q[j] + v_q[j];
      end
    end
  end

  assign word_o = hash_q[word_sel_i];

endmodule

// File: rtl/sha256_stream_hasher.sv
// SHA-256 over a byte stream. Each absorb transaction writes one byte; the 64th byte
// of a block starts a compression (a schedule fetch, 64 rounds and the fold into the
// chaining value).
// A round reads its four schedule operands in two pairs because they come from the
// 16-word block/schedule memory through its two read ports. A finish transaction
// writes padding at one byte per cycle (up to 64, or 72 when the length spills
// into an extra block), runs one or two compressions and then hands out the eight
// digest words, after which the hasher is back at the initial hash values.
// Input stall stays high from the start of a compression or finish until done.
module sha256_stream_hasher (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  s256_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output s256_pkg::out_item_t   out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_COMP  = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam int unsigned AW = s256_pkg::WADDR_W;
  localparam logic [7:0] COMP_LAST = 8'd129;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] total_q, total_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        finishing_q, finishing_d;
  logic        len_block_q, len_block_d;
  logic        pad_first_q, pad_first_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        sent_all_q, sent_all_d;
  logic        out_valid_q, out_valid_d;
  s256_pkg::out_item_t out_q, out_d;

  logic        in_acc;
  logic        even;
  logic [5:0]  t_rd;
  logic [6:0]  t_ex7;
  logic [5:0]  t_ex;
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;

  logic          mem_we;
  logic [3:0]    mem_be;
  logic [AW-1:0] mem_waddr, raddr0, raddr1;
  logic [31:0]   mem_wdata, rdata0, rdata1;
  logic [31:0]   w_new, w_cur, hash_word;

  s256_pkg::round_ctl_t rctl;
  s256_pkg::sched_ctl_t sctl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign even  = !cnt_q[0];
  assign t_rd  = cnt_q[6:1];
  assign t_ex7 = cnt_q[7:1] - 7'd1;
  assign t_ex  = t_ex7[5:0];

  assign raddr0 = even ? AW'(t_rd - 6'd2)  : AW'(t_rd - 6'd15);
  assign raddr1 = even ? AW'(t_rd - 6'd7)  : AW'(t_rd - 6'd16);

  assign bit_len = {total_q[60:0], 3'b000};

  always_comb begin
    logic [63:0] sh;
    sh = bit_len >> {3'd7 - fill_q[2:0], 3'b000};
    if (pad_first_q) begin
      pad_byte = s256_pkg::PAD_BYTE;
    end else if (len_block_q && fill_q[5:3] == 3'd7) begin
      pad_byte = sh[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    sctl.capture = (state_q == ST_COMP) && !even;
    sctl.calc    = (state_q == ST_COMP) && even && cnt_q >= 8'd2 && cnt_q <= 8'd128;
    sctl.early   = (t_ex[5:4] == 2'b00);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_be    = 4'b1000 >> fill_q[1:0];
    mem_waddr = fill_q[5:2];
    mem_wdata = {4{in_data_i.data_byte}};
    if (state_q == ST_COMP) begin
      mem_we    = sctl.calc;
      mem_be    = 4'hf;
      mem_waddr = t_ex[AW-1:0];
      mem_wdata = w_new;
    end else if (state_q == ST_PAD) begin
      mem_we    = 1'b1;
      mem_wdata = {4{pad_byte}};
    end else if (in_acc && in_data_i.command == s256_pkg::CMD_ABSORB) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    finishing_d = finishing_q;
    len_block_d = len_block_q;
    pad_first_d = pad_first_q;
    oidx_d      = oidx_q;
    sent_all_d  = sent_all_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rctl.init    = 1'b0;
    rctl.step    = (state_q == ST_COMP) && !even && cnt_q >= 8'd3;
    rctl.fold    = (state_q == ST_FOLD);
    rctl.restart = 1'b0;
    rctl.k_idx   = t_ex;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == s256_pkg::CMD_ABSORB) begin
            fill_d  = fill_q + 6'd1;
            total_d = total_q + 64'd1;
            if (fill_q == 6'd63) begin
              state_d   = ST_COMP;
              cnt_d     = '0;
              rctl.init = 1'b1;
            end
          end else begin
            finishing_d = 1'b1;
            pad_first_d = 1'b1;
            len_block_d = (fill_q <= 6'd55);
            state_d     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        fill_d      = fill_q + 6'd1;
        pad_first_d = 1'b0;
        if (fill_q == 6'd63) begin
          state_d   = ST_COMP;
          cnt_d     = '0;
          rctl.init = 1'b1;
        end
      end
      ST_COMP: begin
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == COMP_LAST) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!finishing_q) begin
          state_d = ST_IDLE;
        end else if (len_block_q) begin
          state_d     = ST_OUT;
          oidx_d      = '0;
          sent_all_d  = 1'b0;
          out_valid_d = 1'b0;
        end else begin
          // length did not fit, a second block carries it
          len_block_d = 1'b1;
          state_d     = ST_PAD;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          if (sent_all_q) begin
            out_valid_d  = 1'b0;
            rctl.restart = 1'b1;
            total_d      = '0;
            fill_d       = '0;
            finishing_d  = 1'b0;
            state_d      = ST_IDLE;
          end else begin
            out_d.digest_word = hash_word;
            out_d.word_index  = oidx_q;
            out_d.last_word   = (oidx_q == 3'd7);
            out_valid_d       = 1'b1;
            oidx_d            = oidx_q + 3'd1;
            sent_all_d        = (oidx_q == 3'd7);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      cnt_q       <= '0;
      finishing_q <= 1'b0;
      len_block_q <= 1'b0;
      pad_first_q <= 1'b0;
      oidx_q      <= '0;
      sent_all_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      finishing_q <= finishing_d;
      len_block_q <= len_block_d;
      pad_first_q <= pad_first_d;
      oidx_q      <= oidx_d;
      sent_all_q  <= sent_all_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  s256_wmem u_wmem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .be_i     (mem_be),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  s256_sched u_sched (
    .clk_i    (clk_i),
    .ctl_i    (sctl),
    .rdata0_i (rdata0),
    .rdata1_i (rdata1),
    .w_o      (w_new),
    .w_q_o    (w_cur)
  );

  s256_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rctl),
    .w_i        (w_cur),
    .word_sel_i (oidx_q),
    .word_o     (hash_word)
  );

endmodule
